// ===== src/pod_pkg.sv =====
`timescale 1ns / 1ps
// pod_pkg: shared types, constants and helpers of the parking occupancy detector
// no dependencies; used by every module of the block

package pod_pkg;

  localparam int EMA_SHIFT       = 2;
  localparam int MAG_DEBOUNCE    = 2;
  localparam int ABSENT_DEBOUNCE = 3;

  localparam int MAG_CNT_W = $clog2(MAG_DEBOUNCE + 1);
  localparam int ABS_CNT_W = $clog2(ABSENT_DEBOUNCE + 1);
  localparam int EMA_W     = 9 + EMA_SHIFT + 1;

  localparam logic [15:0] DIST_MIN_CM = 16'd2;
  localparam logic [15:0] DIST_MAX_CM = 16'd400;
  localparam int          MS_PER_S    = 1000;

  // floor(x / 1000) = (x * DIV_MAGIC) >> DIV_SHIFT for any 32-bit x
  localparam int          DIV_MAGIC_W = 29;
  localparam logic [DIV_MAGIC_W-1:0] DIV_MAGIC = 29'd274877907;
  localparam int          DIV_SHIFT   = 38;
  localparam int          PROD_W      = 32 + DIV_MAGIC_W;

  localparam int OPQ_DEPTH = 4;
  localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_DIST_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZOMBIE_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAG_THR    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_EN     = 2'd3;

  localparam logic [8:0]  RST_DIST_THR  = 9'd10;
  localparam logic [31:0] RST_ZOMBIE_MS = 32'd3600000;
  localparam logic [30:0] RST_MAG_THR   = 31'd33554432;

  localparam logic [1:0] FUNC_DIST   = 2'd0;
  localparam logic [1:0] FUNC_MAG    = 2'd1;
  localparam logic [1:0] FUNC_STATUS = 2'd2;

  localparam logic [1:0] CODE_IDLE     = 2'd0;
  localparam logic [1:0] CODE_OCCUPIED = 2'd1;
  localparam logic [1:0] CODE_ZOMBIE   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'b001,
    ST_OCCUPIED = 3'b010,
    ST_ZOMBIE   = 3'b100
  } space_state_t;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_DIST   = 2'd1,
    OP_MAG    = 2'd2,
    OP_STATUS = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [15:0]        distance_raw;
    logic signed [15:0] mag_z;
    logic               mag_ok;
    logic [31:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  park_state;
    logic [22:0] occupied_seconds;
    logic [8:0]  distance_cm;
    logic        mag_present;
    logic        led_on;
    logic        status_changed;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic        dist_ok;
    logic [8:0]  dist_val;
    logic        mag_hit;
    logic [31:0] time_ms;
  } op_item_t;

  typedef struct packed {
    logic [1:0]  park_state;
    logic [31:0] elapsed_ms;
    logic [8:0]  distance_cm;
    logic        mag_present;
    logic        led_on;
    logic        status_changed;
  } exec_res_t;

  typedef struct packed {
    logic [8:0]  dist_thr;
    logic [31:0] zombie_ms;
    logic        led_en;
  } back_cfg_t;

  function automatic logic [1:0] park_code(input space_state_t st);
    logic [1:0] code;
    unique case (st)
      ST_IDLE:     code = CODE_IDLE;
      ST_OCCUPIED: code = CODE_OCCUPIED;
      ST_ZOMBIE:   code = CODE_ZOMBIE;
      default:     code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ===== src/pod_front.sv =====
`timescale 1ns / 1ps
// pod_front: input side, classifies each item into an operation and queues it
// depends on pod_pkg

module pod_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  pod_pkg::in_item_t    in_data,
  input  logic [30:0]          mag_thr,
  input  logic                 opq_pop,
  output logic                 opq_empty,
  output pod_pkg::op_item_t    opq_head
);

  pod_pkg::op_item_t op_c;
  logic [15:0] mag_abs;
  logic [31:0] mag_sq;
  logic        wr_en;
  logic        rd_en;

  pod_pkg::op_item_t             opq_mem [pod_pkg::OPQ_DEPTH];
  logic [pod_pkg::OPQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [pod_pkg::OPQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [pod_pkg::OPQ_PTR_W:0]   cnt_r, cnt_nxt;

  always_comb begin
    mag_abs = in_data.mag_z[15] ? (~in_data.mag_z + 16'd1) : in_data.mag_z;
    mag_sq  = {16'd0, mag_abs} * {16'd0, mag_abs};
    op_c.dist_ok  = (in_data.distance_raw >= pod_pkg::DIST_MIN_CM) &&
                    (in_data.distance_raw <= pod_pkg::DIST_MAX_CM);
    op_c.dist_val = in_data.distance_raw[8:0];
    op_c.mag_hit  = mag_sq > {1'b0, mag_thr};
    op_c.time_ms  = in_data.time_ms;
    unique case (in_data.func)
      pod_pkg::FUNC_DIST:   op_c.op = pod_pkg::OP_DIST;
      pod_pkg::FUNC_MAG:    op_c.op = in_data.mag_ok ? pod_pkg::OP_MAG : pod_pkg::OP_NONE;
      pod_pkg::FUNC_STATUS: op_c.op = pod_pkg::OP_STATUS;
      default:              op_c.op = pod_pkg::OP_NONE;
    endcase
  end

  // operation queue
  assign full      = (cnt_r == (pod_pkg::OPQ_PTR_W+1)'(pod_pkg::OPQ_DEPTH));
  assign opq_empty = (cnt_r == '0);
  assign opq_head  = opq_mem[rd_ptr_r];
  assign wr_en     = push && !full;
  assign rd_en     = opq_pop && !opq_empty;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      opq_mem[wr_ptr_r] <= op_c;
    end
  end

endmodule

// ===== src/pod_back.sv =====
`timescale 1ns / 1ps
// pod_back: executes queued operations on the detector state, one per cycle while a result credit is free
// depends on pod_pkg

module pod_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 opq_empty,
  input  pod_pkg::op_item_t    opq_head,
  output logic                 opq_pop,
  input  logic                 credit_ok,
  input  pod_pkg::back_cfg_t   cfg,
  output logic                 res_vld,
  output pod_pkg::exec_res_t   res
);

  logic                          issue;
  logic [8:0]                    smooth_r, smooth_nxt;
  logic                          first_r, first_nxt;
  logic [pod_pkg::MAG_CNT_W-1:0] mag_cnt_r, mag_cnt_nxt;
  logic                          mag_flag_r, mag_flag_nxt;
  logic [pod_pkg::ABS_CNT_W-1:0] abs_cnt_r, abs_cnt_nxt;
  pod_pkg::space_state_t         state_r, state_nxt;
  logic [31:0]                   change_time_r, change_time_nxt;
  logic [31:0]                   elapsed_ms_r, elapsed_ms_nxt;
  logic                          res_vld_r;
  pod_pkg::exec_res_t            res_r, res_c;

  logic [8:0]                    dist_in;
  logic [pod_pkg::EMA_W-1:0]     ema;
  logic [31:0]                   delta_ms;
  logic                          present;
  logic                          absent;

  assign issue   = !opq_empty && credit_ok;
  assign opq_pop = issue;

  always_comb begin
    smooth_nxt      = smooth_r;
    first_nxt       = first_r;
    mag_cnt_nxt     = mag_cnt_r;
    mag_flag_nxt    = mag_flag_r;
    abs_cnt_nxt     = abs_cnt_r;
    state_nxt       = state_r;
    change_time_nxt = change_time_r;
    elapsed_ms_nxt  = elapsed_ms_r;

    dist_in  = opq_head.dist_ok ? opq_head.dist_val : smooth_r;
    ema      = ((pod_pkg::EMA_W'(smooth_r) << pod_pkg::EMA_SHIFT) - pod_pkg::EMA_W'(smooth_r)
               + pod_pkg::EMA_W'(dist_in)) >> pod_pkg::EMA_SHIFT;
    delta_ms = opq_head.time_ms - change_time_r;
    present  = (smooth_r != 9'd0) && (smooth_r < cfg.dist_thr) && mag_flag_r;
    absent   = 1'b0;

    if (issue) begin
      unique case (opq_head.op)
        pod_pkg::OP_DIST: begin
          first_nxt  = 1'b0;
          smooth_nxt = first_r ? dist_in : ema[8:0];
        end
        pod_pkg::OP_MAG: begin
          if (opq_head.mag_hit) begin
            if (mag_cnt_r < pod_pkg::MAG_CNT_W'(pod_pkg::MAG_DEBOUNCE)) begin
              mag_cnt_nxt = mag_cnt_r + 1'b1;
            end
            if (mag_cnt_nxt >= pod_pkg::MAG_CNT_W'(pod_pkg::MAG_DEBOUNCE)) begin
              mag_flag_nxt = 1'b1;
            end
          end else begin
            if (mag_cnt_r != '0) begin
              mag_cnt_nxt = mag_cnt_r - 1'b1;
            end
            if (mag_cnt_nxt == '0) begin
              mag_flag_nxt = 1'b0;
            end
          end
        end
        pod_pkg::OP_STATUS: begin
          if (present) begin
            abs_cnt_nxt = '0;
          end else if (abs_cnt_r < pod_pkg::ABS_CNT_W'(pod_pkg::ABSENT_DEBOUNCE)) begin
            abs_cnt_nxt = abs_cnt_r + 1'b1;
          end
          absent = abs_cnt_nxt >= pod_pkg::ABS_CNT_W'(pod_pkg::ABSENT_DEBOUNCE);
          unique case (state_r)
            pod_pkg::ST_OCCUPIED: begin
              if (absent) begin
                state_nxt       = pod_pkg::ST_IDLE;
                change_time_nxt = opq_head.time_ms;
                elapsed_ms_nxt  = '0;
              end else begin
                elapsed_ms_nxt = delta_ms;
                if (delta_ms >= cfg.zombie_ms) begin
                  state_nxt = pod_pkg::ST_ZOMBIE;
                end
              end
            end
            pod_pkg::ST_ZOMBIE: begin
              if (absent) begin
                state_nxt       = pod_pkg::ST_IDLE;
                change_time_nxt = opq_head.time_ms;
                elapsed_ms_nxt  = '0;
              end else begin
                elapsed_ms_nxt = delta_ms;
                if (delta_ms < cfg.zombie_ms) begin
                  state_nxt = pod_pkg::ST_OCCUPIED;
                end
              end
            end
            pod_pkg::ST_IDLE: begin
              if (present) begin
                state_nxt       = pod_pkg::ST_OCCUPIED;
                change_time_nxt = opq_head.time_ms;
                elapsed_ms_nxt  = '0;
              end
            end
            default: begin
              state_nxt = pod_pkg::ST_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    res_c.park_state     = pod_pkg::park_code(state_nxt);
    res_c.elapsed_ms     = elapsed_ms_nxt;
    res_c.distance_cm    = smooth_nxt;
    res_c.mag_present    = mag_flag_nxt;
    res_c.led_on         = cfg.led_en && (state_nxt == pod_pkg::ST_ZOMBIE);
    res_c.status_changed = (state_nxt != state_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r      <= '0;
      first_r       <= 1'b1;
      mag_cnt_r     <= '0;
      mag_flag_r    <= 1'b0;
      abs_cnt_r     <= '0;
      state_r       <= pod_pkg::ST_IDLE;
      change_time_r <= '0;
      elapsed_ms_r  <= '0;
      res_vld_r     <= 1'b0;
    end else begin
      smooth_r      <= smooth_nxt;
      first_r       <= first_nxt;
      mag_cnt_r     <= mag_cnt_nxt;
      mag_flag_r    <= mag_flag_nxt;
      abs_cnt_r     <= abs_cnt_nxt;
      state_r       <= state_nxt;
      change_time_r <= change_time_nxt;
      elapsed_ms_r  <= elapsed_ms_nxt;
      res_vld_r     <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      res_r <= res_c;
    end
  end

  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule

// ===== src/pod_out.sv =====
`timescale 1ns / 1ps
// pod_out: ms to seconds conversion by reciprocal multiply, result queue, credits
// depends on pod_pkg

module pod_out (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 issue,
  output logic                 credit_ok,
  input  logic                 res_vld,
  input  pod_pkg::exec_res_t   res,
  output logic                 empty,
  input  logic                 pop,
  output pod_pkg::out_item_t   out_data
);

  logic                          prod_vld_r;
  logic [pod_pkg::PROD_W-1:0]    prod_r;
  pod_pkg::exec_res_t            hold_r;
  pod_pkg::out_item_t            push_item;
  logic                          rd_en;

  pod_pkg::out_item_t             resq_mem [pod_pkg::RESQ_DEPTH];
  logic [pod_pkg::RESQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [pod_pkg::RESQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [pod_pkg::RESQ_PTR_W:0]   cnt_r, cnt_nxt;
  logic [pod_pkg::RESQ_PTR_W:0]   resv_r, resv_nxt;

  // slots are reserved at issue so the queue can never overflow
  assign credit_ok = resv_r < (pod_pkg::RESQ_PTR_W+1)'(pod_pkg::RESQ_DEPTH);
  assign empty     = (cnt_r == '0);
  assign rd_en     = pop && !empty;
  assign out_data  = resq_mem[rd_ptr_r];

  always_comb begin
    push_item.park_state       = hold_r.park_state;
    push_item.occupied_seconds = prod_r[pod_pkg::DIV_SHIFT +: 23];
    push_item.distance_cm      = hold_r.distance_cm;
    push_item.mag_present      = hold_r.mag_present;
    push_item.led_on           = hold_r.led_on;
    push_item.status_changed   = hold_r.status_changed;

    wr_ptr_nxt = prod_vld_r ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (prod_vld_r && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!prod_vld_r && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    resv_nxt = resv_r;
    if (issue && !rd_en) begin
      resv_nxt = resv_r + 1'b1;
    end else if (!issue && rd_en) begin
      resv_nxt = resv_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
      resv_r     <= '0;
    end else begin
      prod_vld_r <= res_vld;
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      cnt_r      <= cnt_nxt;
      resv_r     <= resv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      prod_r <= pod_pkg::PROD_W'(res.elapsed_ms) * pod_pkg::PROD_W'(pod_pkg::DIV_MAGIC);
      hold_r <= res;
    end
    if (prod_vld_r) begin
      resq_mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/parking_occupancy_detector.sv =====
`timescale 1ns / 1ps
// parking_occupancy_detector: top level, configuration registers and wiring
// depends on pod_pkg, pod_front, pod_back, pod_out
//
// usage
//   input queue: an item is taken at a clock edge with push high and full low.
//   each item is an ultrasonic sample, a magnetometer sample, a status check
//   or an unused code, and gives exactly one result beat, in order.
//   result queue: the oldest result sits on out_data while empty is low and is
//   taken at an edge with pop high.
//   config port: cfg_ready is always high; a write lands at an edge with
//   cfg_valid high. write only while no item is in flight.
//   an item passes the op queue, res_r, prod_r and the result queue in order.
//   throughput: one item per cycle while result credits last, set by the
//   state update in the execute stage; the seconds value comes from a
//   registered reciprocal multiply behind it.
//   reset (rst_n low, synchronous) clears both queues and all detector state
//   and loads the register defaults; items are taken from the next cycle.
//   when pop stays low the four-entry result queue fills, then the four-entry
//   operation queue, and full rises; nothing is dropped.

module parking_occupancy_detector (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  pod_pkg::in_item_t               in_data,
  output logic                            empty,
  input  logic                            pop,
  output pod_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pod_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pod_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [8:0]          dist_thr_r;
  logic [31:0]         zombie_ms_r;
  logic [30:0]         mag_thr_r;
  logic                led_en_r;
  pod_pkg::back_cfg_t  back_cfg;

  logic                opq_pop;
  logic                opq_empty;
  pod_pkg::op_item_t   opq_head;
  logic                credit_ok;
  logic                res_vld;
  pod_pkg::exec_res_t  res;

  assign cfg_ready = 1'b1;

  // zombie threshold is kept in ms so the state update needs no divide
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_thr_r  <= pod_pkg::RST_DIST_THR;
      zombie_ms_r <= pod_pkg::RST_ZOMBIE_MS;
      mag_thr_r   <= pod_pkg::RST_MAG_THR;
      led_en_r    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pod_pkg::CFG_DIST_THR:   dist_thr_r  <= cfg_data[8:0];
        pod_pkg::CFG_ZOMBIE_THR: zombie_ms_r <= 32'(cfg_data[21:0]) * 32'(pod_pkg::MS_PER_S);
        pod_pkg::CFG_MAG_THR:    mag_thr_r   <= cfg_data[30:0];
        pod_pkg::CFG_LED_EN:     led_en_r    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign back_cfg.dist_thr  = dist_thr_r;
  assign back_cfg.zombie_ms = zombie_ms_r;
  assign back_cfg.led_en    = led_en_r;

  pod_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .mag_thr   (mag_thr_r),
    .opq_pop   (opq_pop),
    .opq_empty (opq_empty),
    .opq_head  (opq_head)
  );

  pod_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .opq_empty (opq_empty),
    .opq_head  (opq_head),
    .opq_pop   (opq_pop),
    .credit_ok (credit_ok),
    .cfg       (back_cfg),
    .res_vld   (res_vld),
    .res       (res)
  );

  pod_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (opq_pop),
    .credit_ok (credit_ok),
    .res_vld   (res_vld),
    .res       (res),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

// ===== src/pod_checker.sv =====
`timescale 1ns / 1ps
// pod_checker: port-level assertions on the result side of the detector
// depends on pod_pkg; bound to parking_occupancy_detector below

module pod_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                empty,
  input logic                pop,
  input pod_pkg::out_item_t  out_data
);

  // no result beat right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> empty)
    else $error("result shown right after reset");

  // an idle space never reports running seconds
  a_idle_no_seconds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.park_state == pod_pkg::CODE_IDLE) |-> out_data.occupied_seconds == '0)
    else $error("idle space with nonzero seconds");

  // alarm led only in zombie state
  a_led_zombie: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.led_on) |-> out_data.park_state == pod_pkg::CODE_ZOMBIE)
    else $error("led lit outside zombie state");

  // a beat that is not taken stays put
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("stalled result beat changed");

endmodule

bind parking_occupancy_detector pod_checker u_pod_checker (.*);

// ===== verif/occupancy_checker.sv =====
`timescale 1ns / 1ps
// occupancy_checker: predicts each result beat of parking_occupancy_detector and compares it
// depends on pod_pkg; watches the input, result and register channels beside the block

module occupancy_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic                           full,
  input  pod_pkg::in_item_t              in_data,
  input  logic                           empty,
  input  logic                           pop,
  input  pod_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [pod_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pod_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             reports_owed,
  output int                             fail_count
);
  import pod_pkg::*;

  localparam logic [21:0] ZOMBIE_RST_S = 22'd3600;

  // register copies
  logic [8:0]  dist_thr;
  logic [21:0] zombie_s;
  logic [30:0] mag_thr;
  logic        led_en;

  // detector state
  logic [8:0]  smooth_cm;
  logic        first_take;
  int          mag_cnt;
  logic        mag_seen;
  int          absent_cnt;
  logic [1:0]  space_st;
  logic [31:0] since_ms;
  logic [31:0] held_s;

  out_item_t   pending_reports [$];
  int          beat_no;

  task automatic flag_error(input string what, input logic [31:0] got,
                            input logic [31:0] want);
    $display("ERROR beat %0d %s: got %0d, want %0d", beat_no, what, got, want);
    fail_count++;
  endtask

  task automatic step_space(input in_item_t it, output out_item_t res);
    logic [1:0]         was;
    logic [31:0]        raw;
    logic signed [31:0] z;
    logic [31:0]        z_abs;
    logic [31:0]        span;
    logic               hit;
    logic               present;
    logic               absent;
    was = space_st;
    case (it.func)
      FUNC_DIST: begin
        raw = 32'(it.distance_raw);
        if (raw < DIST_MIN_CM || raw > DIST_MAX_CM) raw = 32'(smooth_cm);
        if (first_take) begin
          smooth_cm = raw[8:0];
          first_take = 1'b0;
        end else begin
          smooth_cm = 9'((smooth_cm * ((1 << EMA_SHIFT) - 1) + raw) >> EMA_SHIFT);
        end
      end
      FUNC_MAG: begin
        if (it.mag_ok) begin
          z = 32'($signed(it.mag_z));
          z_abs = (z < 0) ? -z : z;
          hit = (z_abs * z_abs) > {1'b0, mag_thr};
          if (hit) begin
            if (mag_cnt < MAG_DEBOUNCE) mag_cnt++;
            if (mag_cnt >= MAG_DEBOUNCE) mag_seen = 1'b1;
          end else begin
            if (mag_cnt > 0) mag_cnt--;
            if (mag_cnt == 0) mag_seen = 1'b0;
          end
        end
      end
      FUNC_STATUS: begin
        present = smooth_cm != 0 && smooth_cm < dist_thr && mag_seen;
        if (present) absent_cnt = 0;
        else if (absent_cnt < ABSENT_DEBOUNCE) absent_cnt++;
        absent = absent_cnt >= ABSENT_DEBOUNCE;
        span = it.time_ms - since_ms;
        case (space_st)
          CODE_OCCUPIED: begin
            if (absent) begin
              space_st = CODE_IDLE;
              since_ms = it.time_ms;
              held_s = '0;
            end else begin
              held_s = span / MS_PER_S;
              if (held_s >= zombie_s) space_st = CODE_ZOMBIE;
            end
          end
          CODE_ZOMBIE: begin
            held_s = span / MS_PER_S;
            if (absent) begin
              space_st = CODE_IDLE;
              since_ms = it.time_ms;
              held_s = '0;
            end else if (held_s < zombie_s) begin
              space_st = CODE_OCCUPIED;
            end
          end
          default: begin
            space_st = CODE_IDLE;
            if (present) begin
              space_st = CODE_OCCUPIED;
              since_ms = it.time_ms;
              held_s = '0;
            end
          end
        endcase
      end
      default: ;
    endcase
    res.park_state       = space_st;
    res.occupied_seconds = held_s[22:0];
    res.distance_cm      = smooth_cm;
    res.mag_present      = mag_seen;
    res.led_on           = led_en && space_st == CODE_ZOMBIE;
    res.status_changed   = space_st != was;
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t fresh;
    if (!rst_n) begin
      dist_thr   = RST_DIST_THR;
      zombie_s   = ZOMBIE_RST_S;
      mag_thr    = RST_MAG_THR;
      led_en     = 1'b1;
      smooth_cm  = '0;
      first_take = 1'b1;
      mag_cnt    = 0;
      mag_seen   = 1'b0;
      absent_cnt = 0;
      space_st   = CODE_IDLE;
      since_ms   = '0;
      held_s     = '0;
      pending_reports.delete();
      beat_no    = 0;
      fail_count = 0;
    end else begin
      // results first: a beat leaving now is older than one arriving now
      if (pop && !empty) begin
        if (pending_reports.size() == 0) begin
          flag_error("beat with nothing predicted", 32'(out_data.park_state), 32'd0);
        end else begin
          want = pending_reports.pop_front();
          if (out_data.park_state !== want.park_state)
            flag_error("park_state", 32'(out_data.park_state), 32'(want.park_state));
          if (out_data.occupied_seconds !== want.occupied_seconds)
            flag_error("occupied_seconds", 32'(out_data.occupied_seconds),
                       32'(want.occupied_seconds));
          if (out_data.distance_cm !== want.distance_cm)
            flag_error("distance_cm", 32'(out_data.distance_cm), 32'(want.distance_cm));
          if (out_data.mag_present !== want.mag_present)
            flag_error("mag_present", 32'(out_data.mag_present), 32'(want.mag_present));
          if (out_data.led_on !== want.led_on)
            flag_error("led_on", 32'(out_data.led_on), 32'(want.led_on));
          if (out_data.status_changed !== want.status_changed)
            flag_error("status_changed", 32'(out_data.status_changed),
                       32'(want.status_changed));
        end
        beat_no++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DIST_THR:   dist_thr = cfg_data[8:0];
          CFG_ZOMBIE_THR: zombie_s = cfg_data[21:0];
          CFG_MAG_THR:    mag_thr  = cfg_data[30:0];
          CFG_LED_EN:     led_en   = cfg_data[0];
          default: ;
        endcase
      end
      if (push && !full) begin
        step_space(in_data, fresh);
        pending_reports.push_back(fresh);
      end
    end
    reports_owed <= pending_reports.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: clock, reset, stimulus and verdict for parking_occupancy_detector
// depends on pod_pkg, the block and occupancy_checker

module tb_top;
  import pod_pkg::*;

  localparam logic [1:0] FUNC_SPARE  = 2'd3;
  localparam int         PHASE_ITEMS = 240;
  localparam int         IDLE_PCT    = 27;
  localparam int         HOLD_CYCLES = 80;
  localparam int         STALL_LIMIT = 1000;
  localparam int         SETTLE      = 12;

  typedef enum {PH_PLAIN, PH_RX_HOLD, PH_TX_PAUSE, PH_NO_GAPS} phase_kind_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  push      = 1'b0;
  logic                  full;
  in_item_t              in_data   = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    reports_owed;
  int                    fail_count;

  logic        quiet        = 1'b0;
  int          hold_asks    = 0;
  logic [8:0]  dist_thr_now = RST_DIST_THR;
  logic [31:0] clock_ms     = '0;

  always #5 clk = ~clk;

  parking_occupancy_detector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  occupancy_checker u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_data      (in_data),
    .empty        (empty),
    .pop          (pop),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .reports_owed (reports_owed),
    .fail_count   (fail_count)
  );

  function automatic in_item_t item_of(input logic [1:0] f, input logic [15:0] raw,
                                       input logic [15:0] z, input logic ok,
                                       input logic [31:0] t);
    in_item_t it;
    it.func         = f;
    it.distance_raw = raw;
    it.mag_z        = z;
    it.mag_ok       = ok;
    it.time_ms      = t;
    return it;
  endfunction

  // car decides whether the readings lean towards a parked car or an empty space
  function automatic in_item_t next_item(input logic car);
    in_item_t it;
    int       pick;
    int       hi;
    int       step;
    it.func         = FUNC_STATUS;
    it.distance_raw = 16'($urandom);
    it.mag_z        = 16'($urandom);
    it.mag_ok       = 1'b1;
    it.time_ms      = $urandom;
    pick = $urandom_range(0, 99);
    hi = (dist_thr_now > 3) ? dist_thr_now - 1 : 2;
    if (hi > 400) hi = 400;
    if (pick < 30) begin
      it.func = FUNC_DIST;
      it.distance_raw = car ? 16'($urandom_range(2, hi)) : 16'($urandom_range(150, 400));
    end else if (pick < 60) begin
      it.func = FUNC_MAG;
      it.mag_z = car ? 16'($urandom_range(8192, 32767)) : 16'($urandom_range(0, 3000));
      if ($urandom_range(0, 1)) it.mag_z = -it.mag_z;
    end else if (pick < 90) begin
      step = $urandom_range(0, 99);
      if (step < 70) clock_ms += $urandom_range(0, 3000);
      else if (step < 90) clock_ms += $urandom_range(3000, 100000);
      else if (step < 98) clock_ms += $urandom_range(100000, 8000000);
      else clock_ms = $urandom;
      it.time_ms = clock_ms;
    end else begin
      case ($urandom_range(0, 3))
        0: it.func = FUNC_SPARE;
        1: begin
          it.func = FUNC_DIST;
          it.distance_raw = $urandom_range(0, 1) ? 16'($urandom_range(0, 1))
                                                 : 16'($urandom_range(401, 65535));
        end
        2: begin
          it.func = FUNC_MAG;
          it.mag_ok = 1'b0;
        end
        default: it.func = FUNC_MAG;
      endcase
    end
    return it;
  endfunction

  task automatic send_beat(input in_item_t it);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk); while (reports_owed != 0);
  endtask

  task automatic set_config(input logic [8:0] dthr, input logic [21:0] zthr,
                            input logic [30:0] mthr, input logic led);
    logic [CFG_IDX_W-1:0]  idx  [4];
    logic [CFG_DATA_W-1:0] vals [4];
    idx[0] = CFG_DIST_THR;
    idx[1] = CFG_ZOMBIE_THR;
    idx[2] = CFG_MAG_THR;
    idx[3] = CFG_LED_EN;
    vals[0] = CFG_DATA_W'(dthr);
    vals[1] = CFG_DATA_W'(zthr);
    vals[2] = mthr;
    vals[3] = CFG_DATA_W'(led);
    drain_results();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    dist_thr_now = dthr;
  endtask

  task automatic run_phase(input int n_items, input phase_kind_t kind);
    int       sent;
    int       seg_left;
    logic     car;
    in_item_t it;
    sent = 0;
    seg_left = 0;
    car = 1'b0;
    quiet <= (kind == PH_NO_GAPS);
    while (sent < n_items) begin
      if (seg_left == 0) begin
        car = 1'($urandom_range(0, 1));
        seg_left = $urandom_range(8, 60);
      end
      if (sent == 40 && kind == PH_RX_HOLD) hold_asks <= hold_asks + 1;
      if (sent == 100 && kind == PH_TX_PAUSE) drain_results();
      it = next_item(car);
      send_beat(it);
      seg_left--;
      sent++;
    end
  endtask

  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: failed first distance, debounce, unused func, wrap, zombie and back
    send_beat(item_of(FUNC_STATUS, 16'd0, 16'h0000, 1'b0, 32'd0));
    send_beat(item_of(FUNC_DIST, 16'd0, 16'h0000, 1'b1, 32'd0));
    send_beat(item_of(FUNC_DIST, 16'd5, 16'h0000, 1'b1, 32'd0));
    send_beat(item_of(FUNC_DIST, 16'd5, 16'h0000, 1'b1, 32'd0));
    send_beat(item_of(FUNC_MAG, 16'd0, 16'h8000, 1'b1, 32'd0));
    send_beat(item_of(FUNC_MAG, 16'd0, 16'h7FFF, 1'b0, 32'd0));
    send_beat(item_of(FUNC_SPARE, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF));
    send_beat(item_of(FUNC_MAG, 16'd0, 16'h7FFF, 1'b1, 32'd0));
    send_beat(item_of(FUNC_STATUS, 16'd0, 16'h0000, 1'b1, 32'hFFFF_F000));
    send_beat(item_of(FUNC_STATUS, 16'd0, 16'h0000, 1'b1, 32'h0000_2000));
    set_config(RST_DIST_THR, 22'd5, RST_MAG_THR, 1'b1);
    send_beat(item_of(FUNC_STATUS, 16'd0, 16'h0000, 1'b1, 32'h0000_3000));
    set_config(RST_DIST_THR, 22'd3600, RST_MAG_THR, 1'b1);
    send_beat(item_of(FUNC_STATUS, 16'd0, 16'h0000, 1'b1, 32'h0000_3100));
    set_config(RST_DIST_THR, 22'd5, RST_MAG_THR, 1'b0);
    send_beat(item_of(FUNC_STATUS, 16'd0, 16'h0000, 1'b1, 32'h0000_3200));
    send_beat(item_of(FUNC_DIST, 16'd400, 16'h0000, 1'b1, 32'd0));
    send_beat(item_of(FUNC_DIST, 16'hFFFF, 16'h0000, 1'b1, 32'd0));
    send_beat(item_of(FUNC_MAG, 16'd0, 16'h0000, 1'b1, 32'd0));
    send_beat(item_of(FUNC_MAG, 16'd0, 16'h0000, 1'b1, 32'd0));
    send_beat(item_of(FUNC_STATUS, 16'd0, 16'h0000, 1'b1, 32'h0000_4000));
    send_beat(item_of(FUNC_STATUS, 16'd0, 16'h0000, 1'b1, 32'h0000_5000));
    send_beat(item_of(FUNC_STATUS, 16'd0, 16'h0000, 1'b1, 32'h0000_6000));
    send_beat(item_of(FUNC_DIST, 16'd1, 16'h0000, 1'b1, 32'd0));
    send_beat(item_of(FUNC_MAG, 16'd0, 16'h0001, 1'b1, 32'd0));

    set_config(RST_DIST_THR, 22'd3600, RST_MAG_THR, 1'b1);
    run_phase(PHASE_ITEMS, PH_PLAIN);
    set_config(9'd400, 22'd5, 31'd0, 1'b1);
    run_phase(PHASE_ITEMS, PH_RX_HOLD);
    set_config(9'd2, 22'd2592000, 31'd1073741824, 1'b0);
    run_phase(PHASE_ITEMS, PH_TX_PAUSE);
    set_config(9'd40, 22'd60, 31'd134217728, 1'b1);
    run_phase(PHASE_ITEMS, PH_NO_GAPS);
    set_config(9'd511, 22'd4194303, 31'd1000, 1'b1);
    run_phase(PHASE_ITEMS, PH_PLAIN);
    set_config(9'd25, 22'd20, RST_MAG_THR, 1'b1);
    run_phase(PHASE_ITEMS, PH_PLAIN);

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && reports_owed == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== parking_occupancy_detector.f =====
src/pod_pkg.sv
src/pod_front.sv
src/pod_back.sv
src/pod_out.sv
src/parking_occupancy_detector.sv
src/pod_checker.sv
verif/occupancy_checker.sv
verif/tb_top.sv
